### src/shp_pkg.sv
`timescale 1ns / 1ps

package shp_pkg;

    // Result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_SHAPE  = 2'd1;
    localparam logic [1:0] KIND_POINT  = 2'd2;

    // Character codes
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_BAR   = 8'h7C;

    // Result queue depth, address width and fill-count width
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = 2;
    localparam int RQ_CW    = 3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         shape_index;
        logic [3:0]         column;
        logic [7:0]         point_index;
        logic [1:0]         coord_index;
        logic signed [15:0] value;
        logic               last;
    } result_t;

    // Results produced by one character: count is 0, 1 or 2
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

endpackage

### src/shp_core.sv
`timescale 1ns / 1ps

module shp_core #(
    parameter int FIELD_CHARS = 4,
    parameter int MAX_SHAPES  = 256,
    parameter int MAX_POINTS  = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            go,
    input  logic [7:0]      text_byte,
    input  logic            final_byte,
    input  logic            header_mode,
    input  logic [3:0]      line_type_code,
    output shp_pkg::push_t  push
);

    localparam int SHAPE_CAP = ((MAX_SHAPES - 1) > 255) ? 255 : (MAX_SHAPES - 1);
    localparam int POINT_CAP = ((MAX_POINTS - 1) > 255) ? 255 : (MAX_POINTS - 1);
    localparam int FC_W      = $clog2(FIELD_CHARS + 1);
    localparam logic [2:0] COORD_BEYOND = 3'd4;
    localparam logic [2:0] COORD_CY     = 3'd3;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_SIGN,
        PH_DIGIT,
        PH_STOP
    } num_phase_t;

    typedef struct packed {
        num_phase_t  phase;
        logic        neg;
        logic [15:0] mag;
    } num_t;

    localparam num_t NUM_CLEAR = '{phase: PH_SKIP, neg: 1'b0, mag: 16'd0};

    // Step a strtol-style number parser by one character
    function automatic num_t num_feed(input num_t p, input logic [7:0] c);
        num_t        r;
        logic        digit;
        logic        ws;
        logic        sgn;
        logic [18:0] m;
        r     = p;
        digit = (c >= shp_pkg::CH_ZERO) && (c <= shp_pkg::CH_NINE);
        ws    = (c == shp_pkg::CH_SPACE) || ((c >= shp_pkg::CH_TAB) && (c <= shp_pkg::CH_CR));
        sgn   = (c == shp_pkg::CH_PLUS) || (c == shp_pkg::CH_MINUS);
        m     = {3'b000, p.mag} * 19'd10 + {11'd0, c - shp_pkg::CH_ZERO};
        if (p.phase == PH_SKIP && sgn)
        begin
            r.neg   = (c == shp_pkg::CH_MINUS);
            r.phase = PH_SIGN;
        end
        else if (!(p.phase == PH_SKIP && ws) && p.phase != PH_STOP)
        begin
            if (digit)
            begin
                r.mag   = (m > 19'd32768) ? 16'h8000 : m[15:0];
                r.phase = PH_DIGIT;
            end
            else
            begin
                r.phase = PH_STOP;
            end
        end
        return r;
    endfunction

    // Signed value of a parser, saturated to 16 bits
    function automatic logic signed [15:0] num_value(input num_t p);
        logic signed [15:0] v;
        if (p.neg)
        begin
            v = 16'(16'd0 - p.mag);
        end
        else if (p.mag > 16'd32767)
        begin
            v = 16'sh7FFF;
        end
        else
        begin
            v = p.mag;
        end
        return v;
    endfunction

    function automatic shp_pkg::result_t mk_res(
        input logic [1:0]         kind,
        input logic [7:0]         sidx,
        input logic [3:0]         col,
        input logic [7:0]         pidx,
        input logic [1:0]         cidx,
        input logic signed [15:0] v
    );
        shp_pkg::result_t r;
        r.kind        = kind;
        r.shape_index = sidx;
        r.column      = col;
        r.point_index = pidx;
        r.coord_index = cidx;
        r.value       = v;
        r.last        = 1'b0;
        return r;
    endfunction

    logic                at_start_reg, at_start_next;
    logic                line_acc_reg, line_acc_next;
    logic                hdr_done_reg, hdr_done_next;
    logic                line_hdr_reg, line_hdr_next;
    logic [3:0]          col_reg, col_next;
    logic [7:0]          shape_cnt_reg, shape_cnt_next;
    logic [7:0]          line_idx_reg, line_idx_next;
    logic signed [15:0]  type_reg, type_next;
    num_t                fnum_reg, fnum_next;
    logic [FC_W-1:0]     fch_reg, fch_next;
    num_t                cnum_reg, cnum_next;
    logic [7:0]          pidx_reg, pidx_next;
    logic [2:0]          cidx_reg, cidx_next;

    shp_pkg::result_t    res0, res1, cand;
    logic [1:0]          nres;
    logic                is_pt_line;
    logic signed [15:0]  fval;

    // Work out the next parser state and the results of one character
    always_comb
    begin
        at_start_next  = at_start_reg;
        line_acc_next  = line_acc_reg;
        hdr_done_next  = hdr_done_reg;
        line_hdr_next  = line_hdr_reg;
        col_next       = col_reg;
        shape_cnt_next = shape_cnt_reg;
        line_idx_next  = line_idx_reg;
        type_next      = type_reg;
        fnum_next      = fnum_reg;
        fch_next       = fch_reg;
        cnum_next      = cnum_reg;
        pidx_next      = pidx_reg;
        cidx_next      = cidx_reg;
        res0           = '0;
        res1           = '0;
        cand           = '0;
        nres           = 2'd0;
        is_pt_line     = 1'b0;
        fval           = '0;

        // Take the accept decision at the first character of a line
        if (at_start_reg)
        begin
            at_start_next = 1'b0;
            line_acc_next = (text_byte >= shp_pkg::CH_ONE) && (text_byte <= shp_pkg::CH_NINE);
            if (line_acc_next)
            begin
                line_hdr_next = header_mode && !hdr_done_reg;
                if (line_hdr_next)
                begin
                    hdr_done_next = 1'b1;
                end
                line_idx_next = shape_cnt_reg;
                if (shape_cnt_reg < 8'(SHAPE_CAP))
                begin
                    shape_cnt_next = shape_cnt_reg + 8'd1;
                end
                col_next  = 4'd0;
                type_next = '0;
                fnum_next = NUM_CLEAR;
                fch_next  = '0;
                cnum_next = NUM_CLEAR;
                pidx_next = 8'd0;
                cidx_next = 3'd0;
            end
        end

        is_pt_line = !line_hdr_next && (col_next == 4'd3)
                     && (type_next == $signed({12'd0, line_type_code}));

        if (line_acc_next)
        begin
            if (text_byte == shp_pkg::CH_BAR || text_byte == shp_pkg::CH_NL)
            begin
                // Close the field and any open coordinate
                fval = num_value(fnum_next);
                if (line_hdr_next)
                begin
                    if (col_next <= 4'd1)
                    begin
                        res0 = mk_res(shp_pkg::KIND_HEADER, line_idx_next, col_next,
                                      8'd0, 2'd0, fval);
                        nres = 2'd1;
                    end
                end
                else
                begin
                    if (is_pt_line && cidx_next <= COORD_CY)
                    begin
                        res0 = mk_res(shp_pkg::KIND_POINT, line_idx_next, 4'd3,
                                      pidx_next, cidx_next[1:0], num_value(cnum_next));
                        nres = 2'd1;
                    end
                    cand = mk_res(shp_pkg::KIND_SHAPE, line_idx_next, col_next,
                                  8'd0, 2'd0, fval);
                    if (nres == 2'd0)
                    begin
                        res0 = cand;
                    end
                    else
                    begin
                        res1 = cand;
                    end
                    nres = nres + 2'd1;
                    if (col_next == 4'd0)
                    begin
                        type_next = fval;
                    end
                end
                fnum_next = NUM_CLEAR;
                fch_next  = '0;
                cnum_next = NUM_CLEAR;
                pidx_next = 8'd0;
                cidx_next = 3'd0;
                if (text_byte == shp_pkg::CH_NL)
                begin
                    at_start_next = 1'b1;
                    line_acc_next = 1'b0;
                end
                else if (col_next < 4'd15)
                begin
                    col_next = col_next + 4'd1;
                end
            end
            else
            begin
                // Feed the field parser for its leading characters only
                if (fch_next < FC_W'(FIELD_CHARS))
                begin
                    fnum_next = num_feed(fnum_next, text_byte);
                    fch_next  = fch_next + FC_W'(1);
                end
                // Split column 3 of a shape line into coordinates
                if (!line_hdr_next && col_next == 4'd3)
                begin
                    if (text_byte == shp_pkg::CH_SPACE || text_byte == shp_pkg::CH_COMMA)
                    begin
                        if (is_pt_line && cidx_next <= COORD_CY)
                        begin
                            res0 = mk_res(shp_pkg::KIND_POINT, line_idx_next, 4'd3,
                                          pidx_next, cidx_next[1:0], num_value(cnum_next));
                            nres = 2'd1;
                        end
                        cnum_next = NUM_CLEAR;
                        if (text_byte == shp_pkg::CH_COMMA)
                        begin
                            if (cidx_next < COORD_BEYOND)
                            begin
                                cidx_next = cidx_next + 3'd1;
                            end
                        end
                        else
                        begin
                            cidx_next = 3'd0;
                            if (pidx_next < 8'(POINT_CAP))
                            begin
                                pidx_next = pidx_next + 8'd1;
                            end
                        end
                    end
                    else
                    begin
                        cnum_next = num_feed(cnum_next, text_byte);
                    end
                end
            end
        end
        else if (text_byte == shp_pkg::CH_NL)
        begin
            at_start_next = 1'b1;
        end

        // Mark the final result of this character
        if (nres == 2'd1)
        begin
            res0.last = 1'b1;
        end
        else if (nres == 2'd2)
        begin
            res1.last = 1'b1;
        end

        // Restart all counters after the last character of a text
        if (final_byte)
        begin
            at_start_next  = 1'b1;
            line_acc_next  = 1'b0;
            hdr_done_next  = 1'b0;
            line_hdr_next  = 1'b0;
            col_next       = 4'd0;
            shape_cnt_next = 8'd0;
            line_idx_next  = 8'd0;
            type_next      = '0;
            fnum_next      = NUM_CLEAR;
            fch_next       = '0;
            cnum_next      = NUM_CLEAR;
            pidx_next      = 8'd0;
            cidx_next      = 3'd0;
        end
    end

    assign push.count = go ? nres : 2'd0;
    assign push.res0  = res0;
    assign push.res1  = res1;

    // Advance the parser state on each processed character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_start_reg  <= 1'b1;
            line_acc_reg  <= 1'b0;
            hdr_done_reg  <= 1'b0;
            line_hdr_reg  <= 1'b0;
            col_reg       <= 4'd0;
            shape_cnt_reg <= 8'd0;
            line_idx_reg  <= 8'd0;
            type_reg      <= '0;
            fnum_reg      <= NUM_CLEAR;
            fch_reg       <= '0;
            cnum_reg      <= NUM_CLEAR;
            pidx_reg      <= 8'd0;
            cidx_reg      <= 3'd0;
        end
        else if (go)
        begin
            at_start_reg  <= at_start_next;
            line_acc_reg  <= line_acc_next;
            hdr_done_reg  <= hdr_done_next;
            line_hdr_reg  <= line_hdr_next;
            col_reg       <= col_next;
            shape_cnt_reg <= shape_cnt_next;
            line_idx_reg  <= line_idx_next;
            type_reg      <= type_next;
            fnum_reg      <= fnum_next;
            fch_reg       <= fch_next;
            cnum_reg      <= cnum_next;
            pidx_reg      <= pidx_next;
            cidx_reg      <= cidx_next;
        end
    end

    // Two results only come from a coordinate closed together with its field
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |-> (push.res0.kind == shp_pkg::KIND_POINT
                                  && push.res1.kind == shp_pkg::KIND_SHAPE))
        else $error("two results not in point then shape order");

    // A pending line start never coexists with an accepted line
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        at_start_reg |-> !line_acc_reg)
        else $error("line start with line still accepted");

    // Header values come from the first two columns only
    a_hdr_col: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0 && push.res0.kind == shp_pkg::KIND_HEADER)
        |-> (push.res0.column <= 4'd1 && push.count == 2'd1))
        else $error("header value from a later column");

endmodule

### src/shp_rfifo.sv
`timescale 1ns / 1ps

module shp_rfifo (
    input  logic              clk,
    input  logic              rst_n,
    input  shp_pkg::push_t    push,
    input  logic              out_ready,
    output logic              out_valid,
    output shp_pkg::result_t  out_res,
    output logic              room
);

    shp_pkg::result_t             mem [shp_pkg::RQ_DEPTH];
    logic [shp_pkg::RQ_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [shp_pkg::RQ_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [shp_pkg::RQ_CW-1:0]    count_reg, count_next;
    logic                         pop;
    logic [shp_pkg::RQ_AW-1:0]    wr_ptr_b;

    assign out_valid = (count_reg != '0);
    assign out_res   = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // Leave room for the two results one character may bring
    assign room      = (count_reg <= shp_pkg::RQ_CW'(shp_pkg::RQ_DEPTH - 2));
    assign wr_ptr_b  = wr_ptr_reg + shp_pkg::RQ_AW'(1);

    // Work out pointers and fill level after this cycle's pushes and pop
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + shp_pkg::RQ_AW'(push.count);
        rd_ptr_next = rd_ptr_reg + shp_pkg::RQ_AW'(pop);
        count_next  = count_reg + shp_pkg::RQ_CW'(push.count) - shp_pkg::RQ_CW'(pop);
    end

    // Store the results of one character
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.res0;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_b] <= push.res1;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= shp_pkg::RQ_CW'(shp_pkg::RQ_DEPTH))
        else $error("result queue overfilled");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> room)
        else $error("results pushed without room");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != shp_pkg::RQ_CW'(shp_pkg::RQ_DEPTH))
        |-> (shp_pkg::RQ_AW'(wr_ptr_reg - rd_ptr_reg) == count_reg[shp_pkg::RQ_AW-1:0]))
        else $error("pointers disagree with fill level");

endmodule

### src/shape_text_field_parser.sv
`timescale 1ns / 1ps

// Shape text field parser: reads shape text one character per transaction and
// emits header values, shape fields and point coordinates.
// Input channel: in_valid/in_ready with text_byte and final_byte. A character
// sits in an input register and is parsed once the result queue has room for
// two results; its results are written to a four-entry result queue.
// Output channel: out_valid/out_ready with kind, shape_index, column,
// point_index, coord_index, value and last; last marks the final result of a
// character. A character giving no result gives no transaction.
// Flow: an accepted character waits in the input register until the queue
// has room; its results leave one per cycle while out_ready is high.
// Throughput: one character per cycle while the queue has room; a character
// with two results gives two output transactions, and the queue depth
// sets how long input continues while the receiver stalls.
// Stall: with out_ready low the queue fills, the input register holds and
// in_ready drops; nothing is lost.
// Configuration: cfg_we with cfg_index 0 (header_mode) or 1 (line_type_code)
// and cfg_data, written while idle. Reset gives header_mode 1,
// line_type_code 1, an empty queue and the parser at the start of a line.

module shape_text_field_parser #(
    parameter int FIELD_CHARS = 4,
    parameter int MAX_SHAPES  = 256,
    parameter int MAX_POINTS  = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         text_byte,
    input  logic               final_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         kind,
    output logic [7:0]         shape_index,
    output logic [3:0]         column,
    output logic [7:0]         point_index,
    output logic [1:0]         coord_index,
    output logic signed [15:0] value,
    output logic               last,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [3:0]         cfg_data
);

    localparam logic CFG_HEADER_MODE = 1'b0;
    localparam logic CFG_LINE_TYPE   = 1'b1;

    logic             hdr_mode_reg;
    logic [3:0]       line_type_reg;
    logic             hold_valid_reg, hold_valid_next;
    logic [7:0]       byte_reg;
    logic             fin_reg;
    logic             go;
    logic             room;
    shp_pkg::push_t   push;
    shp_pkg::result_t out_res;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hdr_mode_reg  <= 1'b1;
            line_type_reg <= 4'd1;
        end
        else if (cfg_we) begin
            case (cfg_index)
                CFG_HEADER_MODE: hdr_mode_reg  <= cfg_data[0];
                CFG_LINE_TYPE:   line_type_reg <= cfg_data;
                default:         hdr_mode_reg  <= hdr_mode_reg;
            endcase
        end
    end

    // Hold one character until the queue can take its results
    assign go       = hold_valid_reg && room;
    assign in_ready = !hold_valid_reg || go;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (in_valid && in_ready) begin
            hold_valid_next = 1'b1;
        end
        else if (go) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_valid_reg <= 1'b0;
        end
        else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            byte_reg <= text_byte;
            fin_reg  <= final_byte;
        end
    end

    shp_core #(
        .FIELD_CHARS (FIELD_CHARS),
        .MAX_SHAPES  (MAX_SHAPES),
        .MAX_POINTS  (MAX_POINTS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .go             (go),
        .text_byte      (byte_reg),
        .final_byte     (fin_reg),
        .header_mode    (hdr_mode_reg),
        .line_type_code (line_type_reg),
        .push           (push)
    );

    shp_rfifo u_rfifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_res   (out_res),
        .room      (room)
    );

    assign kind        = out_res.kind;
    assign shape_index = out_res.shape_index;
    assign column      = out_res.column;
    assign point_index = out_res.point_index;
    assign coord_index = out_res.coord_index;
    assign value       = out_res.value;
    assign last        = out_res.last;

endmodule
